[sv/heat_stencil_3d_7point_unit_macros.svh]
// Assertion macros shared by the heat stencil RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef HEAT_STENCIL_3D_7POINT_UNIT_MACROS_SVH
`define HEAT_STENCIL_3D_7POINT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HS3D_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HS3D_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/hs3d_pkg.sv]
// Shared types and constants of the 3D seven-point heat stencil.
// No dependencies; used by the tracker, the update and the top module.
package hs3d_pkg;

    localparam int DATA_W     = 32;
    localparam int SUM_W      = 36;
    localparam int X_W        = 16;
    localparam int YZ_W       = 7;
    localparam int POS_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_DRAIN  = 1'b1;

    localparam int SIZE_RESET = 64;
    localparam int SIZE_MIN   = 3;

    // Effective grid dimensions and the input-to-output lag in samples
    typedef struct packed {
        logic [X_W-1:0]   nx;
        logic [YZ_W-1:0]  ny;
        logic [YZ_W-1:0]  nz;
        logic [POS_W-1:0] lag;
    } t_dims;

    // Per-transfer decision from the position tracker
    typedef struct packed {
        logic adv;
        logic emit;
        logic inner;
        logic last;
    } t_step;

endpackage

[sv/hs3d_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hs3d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port (read returns old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/hs3d_delay.sv]
// Run-time length delay line: one RAM used as a circular buffer.
// Depends on hs3d_ram. Output changes only on an advance.
module hs3d_delay #(
    parameter int W     = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_adv,
    input  logic [LW-1:0] i_len,
    input  logic [W-1:0]  i_data,
    output logic [W-1:0]  o_data
);

    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;

    // Wrap the slot pointer after len slots
    always_comb begin
        n_ptr = r_ptr;
        if (i_clear) begin
            n_ptr = '0;
        end else if (i_adv) begin
            if (LW'(r_ptr) + LW'(1) >= i_len) begin
                n_ptr = '0;
            end else begin
                n_ptr = r_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    // Read the oldest slot and overwrite it with the new value
    hs3d_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_adv),
        .i_waddr (r_ptr),
        .i_wdata (i_data),
        .i_re    (i_adv),
        .i_raddr (r_ptr),
        .o_rdata (o_data)
    );

endmodule

[sv/hs3d_ctrl.sv]
// Position tracker: input and output grid coordinates, pending count, drain.
// Depends on hs3d_pkg and heat_stencil_3d_7point_unit_macros.svh.
`include "heat_stencil_3d_7point_unit_macros.svh"

module hs3d_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_accept,
    input  logic            i_mode,
    input  hs3d_pkg::t_dims i_dims,
    output hs3d_pkg::t_step o_step
);

    logic [hs3d_pkg::X_W-1:0]   r_ix, n_ix, r_ox, n_ox;
    logic [hs3d_pkg::YZ_W-1:0]  r_iy, n_iy, r_iz, n_iz;
    logic [hs3d_pkg::YZ_W-1:0]  r_oy, n_oy, r_oz, n_oz;
    logic [hs3d_pkg::POS_W-1:0] r_pend, n_pend;
    logic                       r_full, n_full;

    logic is_sample, drain_emit, emit;
    logic ix_end, iy_end, iz_end, ox_end, oy_end, oz_end;

    // Decide what this transfer does
    always_comb begin
        ix_end = (r_ix == i_dims.nx - hs3d_pkg::X_W'(1));
        iy_end = (r_iy == i_dims.ny - hs3d_pkg::YZ_W'(1));
        iz_end = (r_iz == i_dims.nz - hs3d_pkg::YZ_W'(1));
        ox_end = (r_ox == i_dims.nx - hs3d_pkg::X_W'(1));
        oy_end = (r_oy == i_dims.ny - hs3d_pkg::YZ_W'(1));
        oz_end = (r_oz == i_dims.nz - hs3d_pkg::YZ_W'(1));

        is_sample  = i_accept && (i_mode == hs3d_pkg::MODE_SAMPLE) && !r_full;
        drain_emit = i_accept && !is_sample && r_full && (r_pend != '0);
        emit       = (is_sample && (r_pend >= i_dims.lag)) || drain_emit;

        o_step.adv   = is_sample || drain_emit;
        o_step.emit  = emit;
        o_step.inner = (r_ox != '0) && !ox_end && (r_oy != '0) && !oy_end
                    && (r_oz != '0) && !oz_end;
        o_step.last  = ox_end && oy_end && oz_end;
    end

    // Advance coordinates and pending count
    always_comb begin
        n_ix   = r_ix;
        n_iy   = r_iy;
        n_iz   = r_iz;
        n_ox   = r_ox;
        n_oy   = r_oy;
        n_oz   = r_oz;
        n_full = r_full;
        n_pend = r_pend;

        if (is_sample) begin
            if (iz_end) begin
                n_iz = '0;
                if (iy_end) begin
                    n_iy = '0;
                    if (ix_end) begin
                        n_ix   = '0;
                        n_full = 1'b1;
                    end else begin
                        n_ix = r_ix + hs3d_pkg::X_W'(1);
                    end
                end else begin
                    n_iy = r_iy + hs3d_pkg::YZ_W'(1);
                end
            end else begin
                n_iz = r_iz + hs3d_pkg::YZ_W'(1);
            end
        end

        if (emit) begin
            if (oz_end) begin
                n_oz = '0;
                if (oy_end) begin
                    n_oy = '0;
                    n_ox = ox_end ? '0 : r_ox + hs3d_pkg::X_W'(1);
                end else begin
                    n_oy = r_oy + hs3d_pkg::YZ_W'(1);
                end
            end else begin
                n_oz = r_oz + hs3d_pkg::YZ_W'(1);
            end
        end

        case ({is_sample, emit})
            2'b10:   n_pend = r_pend + hs3d_pkg::POS_W'(1);
            2'b01:   n_pend = r_pend - hs3d_pkg::POS_W'(1);
            default: n_pend = r_pend;
        endcase

        // Drop the volume on its final point or on a register write
        if (i_clear || (emit && o_step.last)) begin
            n_ix   = '0;
            n_iy   = '0;
            n_iz   = '0;
            n_ox   = '0;
            n_oy   = '0;
            n_oz   = '0;
            n_full = 1'b0;
            n_pend = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ix   <= '0;
            r_iy   <= '0;
            r_iz   <= '0;
            r_ox   <= '0;
            r_oy   <= '0;
            r_oz   <= '0;
            r_full <= 1'b0;
            r_pend <= '0;
        end else begin
            r_ix   <= n_ix;
            r_iy   <= n_iy;
            r_iz   <= n_iz;
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_oz   <= n_oz;
            r_full <= n_full;
            r_pend <= n_pend;
        end
    end

    `HS3D_CHECK(a_pend_bound, i_clk, i_rst_n, 1'b1, r_pend <= i_dims.lag, "pending count above lag")
    `HS3D_CHECK(a_full_origin, i_clk, i_rst_n, r_full, r_ix == '0 && r_iy == '0 && r_iz == '0, "full volume with input coordinates off origin")
    `HS3D_CHECK(a_full_pending, i_clk, i_rst_n, r_full, r_pend != '0, "full volume with nothing pending")
    `HS3D_CHECK_NEXT(a_last_clears, i_clk, i_rst_n, o_step.emit && o_step.last, r_pend == '0 && !r_full && r_ox == '0, "volume not restarted after final point")

endmodule

[sv/hs3d_calc.sv]
// Seven-point update: c + ((sum of six neighbors - 6c) >>> 3), or c on the boundary.
// Depends on hs3d_pkg.
module hs3d_calc (
    input  logic signed [hs3d_pkg::DATA_W-1:0] i_center,
    input  logic signed [hs3d_pkg::DATA_W-1:0] i_xm,
    input  logic signed [hs3d_pkg::DATA_W-1:0] i_xp,
    input  logic signed [hs3d_pkg::DATA_W-1:0] i_ym,
    input  logic signed [hs3d_pkg::DATA_W-1:0] i_yp,
    input  logic signed [hs3d_pkg::DATA_W-1:0] i_zm,
    input  logic signed [hs3d_pkg::DATA_W-1:0] i_zp,
    input  logic                               i_inner,
    output logic signed [hs3d_pkg::DATA_W-1:0] o_value
);

    logic signed [hs3d_pkg::SUM_W-1:0] c_w, nsum, diff, res;

    // Sum in a width that cannot overflow, then floor-divide by eight
    always_comb begin
        c_w  = hs3d_pkg::SUM_W'(i_center);
        nsum = hs3d_pkg::SUM_W'(i_xm) + hs3d_pkg::SUM_W'(i_xp)
             + hs3d_pkg::SUM_W'(i_ym) + hs3d_pkg::SUM_W'(i_yp)
             + hs3d_pkg::SUM_W'(i_zm) + hs3d_pkg::SUM_W'(i_zp);
        diff = nsum - ((c_w <<< 2) + (c_w <<< 1));
        res  = c_w + (diff >>> 3);
        o_value = i_inner ? res[hs3d_pkg::DATA_W-1:0] : i_center;
    end

endmodule

[sv/heat_stencil_3d_7point_unit.sv]
// Seven-point 3D heat stencil, one explicit time step per streamed volume.
// Point m enters the stencil stage register on the transfer of sample
// m + ny*nz + nz + 1 (or of the drain tick in its place), then the output register.
// Throughput: one transfer per cycle while o_in_stall is low (single-pass datapath).
// Reset: sizes return to 64, positions clear; line buffers are not cleared
// (their contents are undefined until written), so there is no clearing pass.
module heat_stencil_3d_7point_unit #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_mode,
    input  logic signed [hs3d_pkg::DATA_W-1:0]     i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [hs3d_pkg::DATA_W-1:0]     o_value,
    output logic                                   o_last,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [hs3d_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [hs3d_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int DEP_A = MAX_COLS + 1;
    localparam int DEP_B = MAX_COLS * (MAX_ROWS - 1);
    localparam int DEP_C = MAX_COLS;
    localparam int LW_A  = $clog2(DEP_A + 1);
    localparam int LW_B  = $clog2(DEP_B + 1);
    localparam int LW_C  = $clog2(DEP_C + 1);

    localparam int DW  = hs3d_pkg::DATA_W;
    localparam int YW  = hs3d_pkg::YZ_W;
    localparam int PW  = hs3d_pkg::POS_W;

    logic [hs3d_pkg::X_W-1:0] r_size_x;
    logic [YW-1:0]            r_size_y, r_size_z;
    logic                     cfg_we, cfg_clear;

    hs3d_pkg::t_dims dims;
    hs3d_pkg::t_step step;
    logic [PW-1:0]   plane, span_b;
    logic [LW_A-1:0] len_a;
    logic [LW_B-1:0] len_b;
    logic [LW_C-1:0] len_c, len_d;

    logic          out_free, accept;
    logic [DW-1:0] tap_xp, tap_yp, tap_zp, tap_ym, tap_xm;
    logic [DW-1:0] r_ctr, r_zm;
    logic          r_s1_valid, r_s1_inner, r_s1_last;
    logic          r_out_valid, r_last;
    logic [DW-1:0] r_value;
    logic signed [DW-1:0] calc_value;

    // Configuration transfer; a write to a known register restarts the volume
    assign o_cfg_ready = !(r_s1_valid || r_out_valid);
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_clear   = cfg_we && ((i_cfg_index == hs3d_pkg::REG_SIZE_X)
                      || (i_cfg_index == hs3d_pkg::REG_SIZE_Y)
                      || (i_cfg_index == hs3d_pkg::REG_SIZE_Z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= hs3d_pkg::X_W'(hs3d_pkg::SIZE_RESET);
            r_size_y <= YW'(hs3d_pkg::SIZE_RESET);
            r_size_z <= YW'(hs3d_pkg::SIZE_RESET);
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                hs3d_pkg::REG_SIZE_X: r_size_x <= i_cfg_data;
                hs3d_pkg::REG_SIZE_Y: r_size_y <= i_cfg_data[YW-1:0];
                hs3d_pkg::REG_SIZE_Z: r_size_z <= i_cfg_data[YW-1:0];
                default: ;
            endcase
        end
    end

    // Clamp sizes and derive the line buffer lengths
    always_comb begin
        dims.nx = (r_size_x < hs3d_pkg::X_W'(hs3d_pkg::SIZE_MIN))
                ? hs3d_pkg::X_W'(hs3d_pkg::SIZE_MIN) : r_size_x;
        if (r_size_y < YW'(hs3d_pkg::SIZE_MIN)) begin
            dims.ny = YW'(hs3d_pkg::SIZE_MIN);
        end else if (32'(r_size_y) > MAX_ROWS) begin
            dims.ny = YW'(MAX_ROWS);
        end else begin
            dims.ny = r_size_y;
        end
        if (r_size_z < YW'(hs3d_pkg::SIZE_MIN)) begin
            dims.nz = YW'(hs3d_pkg::SIZE_MIN);
        end else if (32'(r_size_z) > MAX_COLS) begin
            dims.nz = YW'(MAX_COLS);
        end else begin
            dims.nz = r_size_z;
        end
        plane    = PW'(dims.ny) * PW'(dims.nz);
        dims.lag = plane + PW'(dims.nz) + PW'(1);
        span_b   = plane - PW'(dims.nz) - PW'(1);
        len_a    = LW_A'(dims.nz) + LW_A'(1);
        len_b    = LW_B'(span_b);
        len_c    = LW_C'(dims.nz) - LW_C'(2);
        len_d    = LW_C'(dims.nz) - LW_C'(2);
    end

    // Handshake: take a transfer unless the stencil stage is blocked
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    hs3d_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_clear),
        .i_accept (accept),
        .i_mode   (i_mode),
        .i_dims   (dims),
        .o_step   (step)
    );

    // Tap chain: x+1, y+1, z+1, center, z-1, y-1, x-1 relative to the emitted point
    hs3d_delay #(.W(DW), .DEPTH(DEP_A)) u_dly_xp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_clear (cfg_clear), .i_adv (step.adv),
        .i_len (len_a), .i_data (i_sample), .o_data (tap_xp)
    );

    hs3d_delay #(.W(DW), .DEPTH(DEP_B)) u_dly_yp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_clear (cfg_clear), .i_adv (step.adv),
        .i_len (len_b), .i_data (tap_xp), .o_data (tap_yp)
    );

    hs3d_delay #(.W(DW), .DEPTH(DEP_C)) u_dly_zp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_clear (cfg_clear), .i_adv (step.adv),
        .i_len (len_c), .i_data (tap_yp), .o_data (tap_zp)
    );

    // Hold center and z-1 in plain registers
    always_ff @(posedge i_clk) begin
        if (step.adv) begin
            r_ctr <= tap_zp;
            r_zm  <= r_ctr;
        end
    end

    hs3d_delay #(.W(DW), .DEPTH(DEP_C)) u_dly_ym (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_clear (cfg_clear), .i_adv (step.adv),
        .i_len (len_d), .i_data (r_zm), .o_data (tap_ym)
    );

    hs3d_delay #(.W(DW), .DEPTH(DEP_B)) u_dly_xm (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_clear (cfg_clear), .i_adv (step.adv),
        .i_len (len_b), .i_data (tap_ym), .o_data (tap_xm)
    );

    // Stencil stage: taps are valid while r_s1_valid is set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= step.emit;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && step.emit) begin
            r_s1_inner <= step.inner;
            r_s1_last  <= step.last;
        end
    end

    hs3d_calc u_calc (
        .i_center (r_ctr),
        .i_xm     (tap_xm),
        .i_xp     (tap_xp),
        .i_ym     (tap_ym),
        .i_yp     (tap_yp),
        .i_zm     (r_zm),
        .i_zp     (tap_zp),
        .i_inner  (r_s1_inner),
        .o_value  (calc_value)
    );

    // Output register: load when empty or when the current result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_value <= calc_value;
            r_last  <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule
